@@ rtl/core/stl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table package
// Shared constants, codes and types of the session table core.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int ENTRIES_DEF   = 8;
  localparam int TIME_BITS_DEF = 48;

  localparam int OP_W    = 2;
  localparam int TOKEN_W = 64;
  localparam int CFG_W   = 48;
  localparam int CODE_W  = 3;
  localparam int SLOT_W  = 3;
  localparam int OUT_W   = 8;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 48'd600000000;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [CODE_W-1:0] RC_EMPTY        = 3'd0;
  localparam logic [CODE_W-1:0] RC_EXPIRED_SLOT = 3'd1;
  localparam logic [CODE_W-1:0] RC_EVICTED      = 3'd2;
  localparam logic [CODE_W-1:0] RC_HIT          = 3'd3;
  localparam logic [CODE_W-1:0] RC_MISS         = 3'd4;
  localparam logic [CODE_W-1:0] RC_EXPIRED      = 3'd5;
  localparam logic [CODE_W-1:0] RC_CLEARED      = 3'd6;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
  } stl_res_t;

endpackage

@@ rtl/core/session_table_idle_expiry_lru_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table with idle expiry and LRU eviction
// Keeps 128-bit session tokens with last-activity times; create, touch, clear.
// ----------------------------------------------------------------------------
// The core handles one beat at a time. Create and touch go from acceptance
// through a scan state, in which the token and time memories are read one
// entry per cycle on a single read port, then a decision state, a write-back
// state and a hand-off state that waits until the output register takes the
// result. Clear and the unused opcode go straight to the hand-off state. A
// finished result sits in the output register while the core already takes
// the next beat. The timeout register may only be written while the core is idle.
module session_table_idle_expiry_lru_core
  import stl_pkg::*;
#(
  parameter int ENTRIES   = stl_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = stl_pkg::TIME_BITS_DEF,
  parameter int IN_W      = ((stl_pkg::OP_W + 2 * stl_pkg::TOKEN_W + TIME_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // opcode, token_high, token_low, now_us
  input  logic [IN_W-1:0]           in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // result_code, slot_index
  output logic [stl_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_wr_en,
  input  logic [stl_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int TOK_HI_LSB = OP_W;
  localparam int TOK_LO_LSB = OP_W + TOKEN_W;
  localparam int NOW_LSB    = OP_W + 2 * TOKEN_W;

  logic [CFG_W-1:0] timeout_r;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic             res_valid;
  logic             res_ready;
  stl_res_t         res;

  stl_ctrl #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_op     (in_tdata[OP_W-1:0]),
    .req_tok_hi (in_tdata[TOK_HI_LSB +: TOKEN_W]),
    .req_tok_lo (in_tdata[TOK_LO_LSB +: TOKEN_W]),
    .req_now    (in_tdata[NOW_LSB +: TIME_BITS]),
    .timeout    (timeout_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (res_valid && res_ready) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {{(OUT_W - CODE_W - SLOT_W){1'b0}}, res.slot, res.code};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/core/stl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table RAM
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module stl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/stl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table controller
// Walks the token and time memories one entry per cycle for create and touch,
// decides the slot and writes back the chosen entry, if any.
// ----------------------------------------------------------------------------
module stl_ctrl
  import stl_pkg::*;
#(
  parameter int ENTRIES   = stl_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = stl_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [stl_pkg::OP_W-1:0]    req_op,
  input  logic [stl_pkg::TOKEN_W-1:0] req_tok_hi,
  input  logic [stl_pkg::TOKEN_W-1:0] req_tok_lo,
  input  logic [TIME_BITS-1:0]        req_now,
  input  logic [stl_pkg::CFG_W-1:0]   timeout,
  output logic                        res_valid,
  input  logic                        res_ready,
  output stl_pkg::stl_res_t           res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int TOK_W = 2 * TOKEN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [OP_W-1:0]      op_r;
  logic [TOK_W-1:0]     tok_r;
  logic [TIME_BITS-1:0] now_r;
  logic [ENTRIES-1:0]   valid_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [IDX_W-1:0]     ev_idx_r;
  logic                 ev_v_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [CODE_W-1:0]    code_r;
  logic [TIME_BITS-1:0] min_r;
  logic [IDX_W-1:0]     min_idx_r;
  stl_res_t             res_r;

  logic [TOK_W-1:0]     tok_rd;
  logic [TIME_BITS-1:0] tm_rd;
  logic                 ev_vld;
  logic                 ev_match;
  logic                 ev_expired;
  logic                 ev_less;
  logic [TIME_BITS-1:0] ev_diff;

  logic                 wr_tok;
  logic                 wr_tm;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     fin_idx;
  logic [CODE_W-1:0]    fin_code;
  logic [IDX_W+SLOT_W-1:0] fin_slot_ext;

  stl_ram #(.WIDTH(TOK_W), .DEPTH(ENTRIES)) u_tok_ram (
    .clk   (clk),
    .we    (wr_tok),
    .waddr (wr_idx),
    .wdata (tok_r),
    .raddr (rd_idx_r),
    .rdata (tok_rd)
  );

  stl_ram #(.WIDTH(TIME_BITS), .DEPTH(ENTRIES)) u_time_ram (
    .clk   (clk),
    .we    (wr_tm),
    .waddr (wr_idx),
    .wdata (now_r),
    .raddr (rd_idx_r),
    .rdata (tm_rd)
  );

  always_comb begin
    ev_vld     = valid_r[ev_idx_r];
    ev_match   = (tok_rd == tok_r);
    ev_diff    = now_r - tm_rd;
    ev_expired = (now_r > tm_rd) && (CMP_W'(ev_diff) > CMP_W'(timeout));
    ev_less    = (tm_rd < min_r);
  end

  always_comb begin
    fin_idx  = '0;
    fin_code = RC_MISS;
    if (op_r == OP_CREATE) begin
      fin_idx  = found_r ? pick_r : min_idx_r;
      fin_code = found_r ? code_r : RC_EVICTED;
    end else if (found_r) begin
      fin_idx  = pick_r;
      fin_code = code_r;
    end
    fin_slot_ext = {{SLOT_W{1'b0}}, fin_idx};
    wr_idx       = fin_idx;
    wr_tok       = (state_r == ST_WRITE) && (op_r == OP_CREATE);
    wr_tm        = (state_r == ST_WRITE) &&
                   ((op_r == OP_CREATE) || (found_r && code_r == RC_HIT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      ev_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      ev_v_r   <= (state_r == ST_SCAN);
      ev_idx_r <= rd_idx_r;
      unique case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            op_r     <= req_op;
            tok_r    <= {req_tok_hi, req_tok_lo};
            now_r    <= req_now;
            rd_idx_r <= '0;
            found_r  <= 1'b0;
            if (req_op == OP_CLEAR) begin
              valid_r <= '0;
              res_r   <= '{code: RC_CLEARED, slot: '0};
              state_r <= ST_DONE;
            end else if (req_op == OP_CREATE || req_op == OP_TOUCH) begin
              state_r <= ST_SCAN;
            end else begin
              res_r   <= '{code: RC_MISS, slot: '0};
              state_r <= ST_DONE;
            end
          end
        end
        ST_SCAN, ST_FINISH: begin
          if (state_r == ST_SCAN) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            if (rd_idx_r == LAST_IDX) begin
              state_r <= ST_FINISH;
            end
          end else begin
            state_r <= ST_WRITE;
          end
          if (ev_v_r) begin
            if (op_r == OP_CREATE) begin
              if (!found_r) begin
                if (!ev_vld) begin
                  found_r <= 1'b1;
                  pick_r  <= ev_idx_r;
                  code_r  <= RC_EMPTY;
                end else if (ev_expired) begin
                  found_r <= 1'b1;
                  pick_r  <= ev_idx_r;
                  code_r  <= RC_EXPIRED_SLOT;
                end
              end
              if (ev_idx_r == '0 || ev_less) begin
                min_r     <= tm_rd;
                min_idx_r <= ev_idx_r;
              end
            end else if (!found_r && ev_vld && ev_match) begin
              found_r <= 1'b1;
              pick_r  <= ev_idx_r;
              code_r  <= ev_expired ? RC_EXPIRED : RC_HIT;
            end
          end
        end
        ST_WRITE: begin
          if (op_r == OP_CREATE) begin
            valid_r[fin_idx] <= 1'b1;
          end else if (found_r && code_r == RC_EXPIRED) begin
            valid_r[fin_idx] <= 1'b0;
          end
          res_r   <= '{code: fin_code, slot: fin_slot_ext[SLOT_W-1:0]};
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

@@ rtl/core/stl_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table port checker
// Watches the ports of the core over time and reports violations.
// ----------------------------------------------------------------------------
module stl_chk
  import stl_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result beat changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken again right after a beat.");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CODE_W-1:0] != 3'd7 &&
                   out_tdata[OUT_W-1:CODE_W+SLOT_W] == '0)
    else $error("Result beat carries an undefined code or padding.");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[CODE_W-1:0] == RC_MISS ||
                   out_tdata[CODE_W-1:0] == RC_CLEARED)
    |-> out_tdata[CODE_W+SLOT_W-1:CODE_W] == '0)
    else $error("Miss or clear reported a nonzero slot.");

endmodule

bind session_table_idle_expiry_lru_core stl_chk u_stl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
